/* rtl/core/refcounted_location_allocator_unit_assert.svh */
`ifndef REFCOUNTED_LOCATION_ALLOCATOR_UNIT_ASSERT_SVH
`define REFCOUNTED_LOCATION_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RLA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rla_pkg.sv */
package rla_pkg;

	localparam int LocCap = 64;
	localparam int LocW = $clog2(LocCap);
	localparam int PtrW = LocW + 1;
	localparam int MaxRegs = 6;
	localparam logic [PtrW-1:0] EMPTY_MARK = PtrW'(LocCap);
	localparam logic [6:0] COUNT_MAX = 7'd127;

	localparam logic [2:0] MACHINE_REG [8] = '{3'd0, 3'd3, 3'd1, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5};

	typedef enum logic [2:0] {
		FUNC_INIT        = 3'd0,
		FUNC_ALLOC_REG   = 3'd1,
		FUNC_ALLOC_STACK = 3'd2,
		FUNC_CLAIM       = 3'd3,
		FUNC_USE         = 3'd4,
		FUNC_RELEASE     = 3'd5,
		FUNC_EXTEND      = 3'd6,
		FUNC_QUERY       = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_REG    = 3'd1,
		ST_NO_STACK  = 3'd2,
		ST_NOT_FREE  = 3'd3,
		ST_NOT_ALLOC = 3'd4,
		ST_BAD_LOC   = 3'd5,
		ST_SATURATED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		REG_ARGS  = 2'd0,
		REG_REGS  = 2'd1,
		REG_STACK = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_RMW,
		FSM_INIT,
		FSM_EXTEND,
		FSM_WALK,
		FSM_TAKE
	} fsm_t;

endpackage

/* rtl/core/refcounted_location_allocator_unit.sv */
// steps: query, use, release, list allocate: table read, then write back if the entry changes;
//   append allocate, empty-list and bad-location errors end in idle; init writes each location;
//   extend appends the new slots; claim reads, walks the list to the location, then takes it
// throughput: one request per result; the table read-modify-write sets the rate
// reset: lists empty, no locations, config regs at argument 0, register 6, stack 0;
//   the table itself is not cleared, init rewrites every live entry; results cannot stall
`include "refcounted_location_allocator_unit_assert.svh"

module refcounted_location_allocator_unit
	import rla_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// command side
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        func,
	input  logic [5:0]        location,
	input  logic [6:0]        target_count,
	// result side
	output logic              done,
	output logic [2:0]        status,
	output logic [5:0]        result_location,
	output logic [6:0]        use_count,
	output logic [7:0]        free_reg_mask,
	output logic [7:0]        used_reg_mask,
	output logic [2:0]        free_reg_count,
	output logic signed [6:0] frame_offset,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// entry: {free flag, link or use count}
	logic [7:0] mem [LocCap];
	logic [7:0] rdata_q;
	logic mem_we, mem_re;
	logic [LocW-1:0] mem_waddr, mem_raddr;
	logic [7:0] mem_wdata;

	fsm_t state_q, state_d;

	// config registers
	logic [3:0] cfg_args_q;
	logic [2:0] cfg_regs_q;
	logic [6:0] cfg_stack_q;

	// latched request
	func_t func_q, func_d;
	logic [LocW-1:0] loc_q, loc_d;
	logic [6:0] target_q, target_d;

	// allocator state
	logic [3:0] args_q, args_d;
	logic [2:0] regs_q, regs_d;
	logic [PtrW-1:0] total_q, total_d;
	logic [PtrW-1:0] rhead_q, rhead_d;
	logic [PtrW-1:0] shead_q, shead_d;
	logic [2:0] free_cnt_q, free_cnt_d;
	logic [MaxRegs-1:0] reg_free_q, reg_free_d;

	// sequencing
	logic [PtrW-1:0] idx_q, idx_d;
	logic [PtrW-1:0] prev_q, prev_d;
	logic [PtrW-1:0] link_q, link_d;

	// result registers
	status_t status_q, status_d;
	logic [LocW-1:0] rloc_q, rloc_d;
	logic [6:0] count_q, count_d;
	logic report_q, report_d;
	logic done_q, done_d;

	// apb
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		case (reg_idx_t'(paddr[3:2]))
			REG_ARGS:  prdata = {28'd0, cfg_args_q};
			REG_REGS:  prdata = {29'd0, cfg_regs_q};
			REG_STACK: prdata = {25'd0, cfg_stack_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_args_q  <= 4'd0;
			cfg_regs_q  <= 3'd6;
			cfg_stack_q <= 7'd0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_ARGS:  cfg_args_q  <= pwdata[3:0];
				REG_REGS:  cfg_regs_q  <= pwdata[2:0];
				REG_STACK: cfg_stack_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// table, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// classification of the latched location
	logic [PtrW-1:0] loc7, base7, args7;
	logic loc_is_arg, loc_is_reg;
	logic [2:0] loc_slot;
	assign loc7 = {1'b0, loc_q};
	assign args7 = {3'd0, args_q};
	assign base7 = args7 + {4'd0, regs_q};
	assign loc_is_arg = loc7 < args7;
	assign loc_is_reg = !loc_is_arg && (loc7 < base7);
	assign loc_slot = 3'(loc7 - args7);

	// init sizing from config
	logic [2:0] init_r;
	logic [6:0] init_s, init_smax, init_total, init_base;
	logic init_rclamp, init_sclamp;
	always_comb begin
		init_rclamp = cfg_regs_q > 3'(MaxRegs);
		init_r = init_rclamp ? 3'(MaxRegs) : cfg_regs_q;
		init_base = {3'd0, cfg_args_q} + {4'd0, init_r};
		init_smax = 7'(LocCap) - init_base;
		init_sclamp = cfg_stack_q > init_smax;
		init_s = init_sclamp ? init_smax : cfg_stack_q;
		init_total = init_base + init_s;
	end

	logic [6:0] val;
	logic fr;
	logic [PtrW-1:0] list_head;
	logic [6:0] rel_cnt;
	logic [2:0] head_slot;
	assign val = rdata_q[6:0];
	assign fr = rdata_q[7];
	assign list_head = loc_is_reg ? rhead_q : shead_q;
	assign rel_cnt = val - 7'd1;

	always_comb begin
		state_d = state_q;
		func_d = func_q;
		loc_d = loc_q;
		target_d = target_q;
		args_d = args_q;
		regs_d = regs_q;
		total_d = total_q;
		rhead_d = rhead_q;
		shead_d = shead_q;
		free_cnt_d = free_cnt_q;
		reg_free_d = reg_free_q;
		idx_d = idx_q;
		prev_d = prev_q;
		link_d = link_q;
		status_d = status_q;
		rloc_d = rloc_q;
		count_d = count_q;
		report_d = report_q;
		done_d = 1'b0;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = '0;
		head_slot = 3'(rhead_q - args7);

		case (state_q)
			FSM_IDLE: begin
				if (start) begin
					func_d = func_t'(func);
					loc_d = location;
					target_d = target_count;
					status_d = ST_OK;
					rloc_d = '0;
					count_d = '0;
					report_d = 1'b0;
					case (func_t'(func))
						FUNC_INIT: begin
							args_d = cfg_args_q;
							regs_d = init_r;
							total_d = init_total;
							rhead_d = (init_r != 3'd0) ? init_base - 7'd1 : EMPTY_MARK;
							shead_d = (init_s != 7'd0) ? init_total - 7'd1 : EMPTY_MARK;
							free_cnt_d = init_r;
							for (int k = 0; k < MaxRegs; k++) begin
								reg_free_d[k] = 3'(k) < init_r;
							end
							if (init_rclamp) status_d = ST_NO_REG;
							if (init_sclamp) status_d = ST_NO_STACK;
							idx_d = '0;
							if (init_total != 7'd0) state_d = FSM_INIT;
							else done_d = 1'b1;
						end
						FUNC_ALLOC_REG: begin
							if (rhead_q >= total_q) begin
								status_d = ST_NO_REG;
								done_d = 1'b1;
							end else begin
								mem_re = 1'b1;
								mem_raddr = rhead_q[LocW-1:0];
								state_d = FSM_RMW;
							end
						end
						FUNC_ALLOC_STACK: begin
							if (shead_q < total_q) begin
								mem_re = 1'b1;
								mem_raddr = shead_q[LocW-1:0];
								state_d = FSM_RMW;
							end else if (total_q >= EMPTY_MARK) begin
								status_d = ST_NO_STACK;
								done_d = 1'b1;
							end else begin
								// append a fresh slot already taken
								mem_we = 1'b1;
								mem_waddr = total_q[LocW-1:0];
								mem_wdata = {1'b0, 7'd1};
								rloc_d = total_q[LocW-1:0];
								total_d = total_q + 7'd1;
								count_d = 7'd1;
								report_d = 1'b1;
								done_d = 1'b1;
							end
						end
						FUNC_EXTEND: begin
							state_d = FSM_EXTEND;
						end
						default: begin
							rloc_d = location;
							if ({1'b0, location} >= total_q) begin
								status_d = ST_BAD_LOC;
								done_d = 1'b1;
							end else if (func_t'(func) == FUNC_CLAIM
									&& {1'b0, location} < args7) begin
								status_d = ST_BAD_LOC;
								done_d = 1'b1;
							end else begin
								mem_re = 1'b1;
								mem_raddr = location;
								report_d = 1'b1;
								state_d = FSM_RMW;
							end
						end
					endcase
				end
			end

			FSM_INIT: begin
				// one entry per cycle, lists built in push order
				mem_we = 1'b1;
				mem_waddr = idx_q[LocW-1:0];
				if (idx_q < args7) begin
					mem_wdata = 8'd0;
				end else if (idx_q < base7) begin
					mem_wdata = {1'b1, (idx_q == args7) ? EMPTY_MARK : idx_q - 7'd1};
				end else begin
					mem_wdata = {1'b1, (idx_q == base7) ? EMPTY_MARK : idx_q - 7'd1};
				end
				idx_d = idx_q + 7'd1;
				if (idx_d >= total_q) begin
					state_d = FSM_IDLE;
					done_d = 1'b1;
				end
			end

			FSM_EXTEND: begin
				if ((total_q - base7) < target_q && total_q < EMPTY_MARK) begin
					mem_we = 1'b1;
					mem_waddr = total_q[LocW-1:0];
					mem_wdata = {1'b1, shead_q};
					shead_d = total_q;
					total_d = total_q + 7'd1;
				end else begin
					if ((total_q - base7) < target_q) status_d = ST_NO_STACK;
					state_d = FSM_IDLE;
					done_d = 1'b1;
				end
			end

			FSM_RMW: begin
				state_d = FSM_IDLE;
				done_d = 1'b1;
				case (func_q)
					FUNC_ALLOC_REG: begin
						mem_we = 1'b1;
						mem_waddr = rhead_q[LocW-1:0];
						mem_wdata = {1'b0, 7'd1};
						rloc_d = rhead_q[LocW-1:0];
						rhead_d = val;
						free_cnt_d = free_cnt_q - 3'd1;
						reg_free_d[head_slot] = 1'b0;
						count_d = 7'd1;
						report_d = 1'b1;
					end
					FUNC_ALLOC_STACK: begin
						mem_we = 1'b1;
						mem_waddr = shead_q[LocW-1:0];
						mem_wdata = {1'b0, 7'd1};
						rloc_d = shead_q[LocW-1:0];
						shead_d = val;
						count_d = 7'd1;
						report_d = 1'b1;
					end
					FUNC_USE: begin
						if (fr) begin
							status_d = ST_NOT_ALLOC;
							count_d = '0;
						end else if (val >= COUNT_MAX) begin
							status_d = ST_SATURATED;
							count_d = val;
						end else begin
							mem_we = 1'b1;
							mem_waddr = loc_q;
							mem_wdata = {1'b0, val + 7'd1};
							count_d = val + 7'd1;
						end
					end
					FUNC_RELEASE: begin
						if (fr || val == 7'd0) begin
							status_d = ST_NOT_ALLOC;
							count_d = '0;
						end else begin
							mem_we = 1'b1;
							mem_waddr = loc_q;
							count_d = rel_cnt;
							if (rel_cnt == 7'd0 && !loc_is_arg) begin
								// back onto the head of its list
								mem_wdata = {1'b1, list_head};
								if (loc_is_reg) begin
									rhead_d = loc7;
									free_cnt_d = free_cnt_q + 3'd1;
									reg_free_d[loc_slot] = 1'b1;
								end else begin
									shead_d = loc7;
								end
							end else begin
								mem_wdata = {1'b0, rel_cnt};
							end
						end
					end
					FUNC_CLAIM: begin
						if (!fr) begin
							status_d = ST_NOT_FREE;
							count_d = val;
						end else begin
							link_d = val;
							if (list_head == loc7) begin
								if (loc_is_reg) rhead_d = val;
								else shead_d = val;
								state_d = FSM_TAKE;
								done_d = 1'b0;
							end else if (list_head >= EMPTY_MARK) begin
								state_d = FSM_TAKE;
								done_d = 1'b0;
							end else begin
								mem_re = 1'b1;
								mem_raddr = list_head[LocW-1:0];
								prev_d = list_head;
								state_d = FSM_WALK;
								done_d = 1'b0;
							end
						end
					end
					default: begin
						count_d = fr ? 7'd0 : val;
					end
				endcase
			end

			FSM_WALK: begin
				// rdata_q holds the entry at prev_q
				if (val == loc7) begin
					mem_we = 1'b1;
					mem_waddr = prev_q[LocW-1:0];
					mem_wdata = {1'b1, link_q};
					state_d = FSM_TAKE;
				end else if (val >= EMPTY_MARK) begin
					state_d = FSM_TAKE;
				end else begin
					mem_re = 1'b1;
					mem_raddr = val[LocW-1:0];
					prev_d = val;
				end
			end

			FSM_TAKE: begin
				mem_we = 1'b1;
				mem_waddr = loc_q;
				mem_wdata = {1'b0, 7'd1};
				if (loc_is_reg) begin
					free_cnt_d = free_cnt_q - 3'd1;
					reg_free_d[loc_slot] = 1'b0;
				end
				count_d = 7'd1;
				state_d = FSM_IDLE;
				done_d = 1'b1;
			end

			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			args_q     <= '0;
			regs_q     <= '0;
			total_q    <= '0;
			rhead_q    <= EMPTY_MARK;
			shead_q    <= EMPTY_MARK;
			free_cnt_q <= '0;
			reg_free_q <= '0;
			done_q     <= 1'b0;
			report_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			args_q     <= args_d;
			regs_q     <= regs_d;
			total_q    <= total_d;
			rhead_q    <= rhead_d;
			shead_q    <= shead_d;
			free_cnt_q <= free_cnt_d;
			reg_free_q <= reg_free_d;
			done_q     <= done_d;
			report_q   <= report_d;
		end
	end

	// payload and scratch registers
	always_ff @(posedge clk) begin
		func_q   <= func_d;
		loc_q    <= loc_d;
		target_q <= target_d;
		idx_q    <= idx_d;
		prev_q   <= prev_d;
		link_q   <= link_d;
		status_q <= status_d;
		rloc_q   <= rloc_d;
		count_q  <= count_d;
	end

	// result ports: masks and offset follow the state left by the request
	logic [PtrW-1:0] rl7;
	assign rl7 = {1'b0, rloc_q};

	always_comb begin
		free_reg_mask = '0;
		used_reg_mask = '0;
		for (int k = 0; k < MaxRegs; k++) begin
			if (3'(k) < regs_q) begin
				if (reg_free_q[k]) free_reg_mask[MACHINE_REG[k]] = 1'b1;
				else used_reg_mask[MACHINE_REG[k]] = 1'b1;
			end
		end
		if (!report_q) frame_offset = '0;
		else if (rl7 < args7) frame_offset = args7 + 7'd1 - rl7;
		else if (rl7 < base7) frame_offset = '0;
		else frame_offset = base7 - 7'd1 - rl7;
	end

	assign busy = state_q != FSM_IDLE;
	assign done = done_q;
	assign status = status_q;
	assign result_location = rloc_q;
	assign use_count = count_q;
	assign free_reg_count = free_cnt_q;

	`RLA_ASSERT_IMP(a_free_cnt_bound, 1'b1, free_cnt_q <= regs_q, "free count above register count")
	`RLA_ASSERT_IMP(a_free_cnt_mirror, 1'b1, $countones(reg_free_q) == free_cnt_q,
		"free register bits disagree with free count")
	`RLA_ASSERT_NXT(a_accept_progress, start && !busy, busy || done_q, "accepted request vanished")
	`RLA_ASSERT_IMP(a_rhead_valid, 1'b1, rhead_q == EMPTY_MARK || rhead_q < base7,
		"register head outside register range")

endmodule
